// ----- src/ladder_lowpass_zdf_filter_assert.svh -----
// Assertion macros for the ladder filter.
// LZF_ASSERT checks a property at each clock edge outside reset.
// LZF_ASSERT_RST checks a property at each clock edge, reset included.
`ifndef LADDER_LOWPASS_ZDF_FILTER_ASSERT_SVH
`define LADDER_LOWPASS_ZDF_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LZF_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LZF_ASSERT_RST(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LZF_ASSERT(name, prop, msg)
`define LZF_ASSERT_RST(name, prop, msg)
`endif
`endif

// ----- src/lzf_pkg.sv -----
package lzf_pkg;

	localparam int AW = 36;           // multiplicand width (signed)
	localparam int BW = 25;           // multiplier width (unsigned), one bit per cycle
	localparam int PW = AW + 1 + BW;  // product register width
	localparam int CW = 5;            // bit counter width

	// register indexes
	localparam logic [1:0] REG_STAGE_GAIN = 2'd0;
	localparam logic [1:0] REG_STATE_GAIN = 2'd1;
	localparam logic [1:0] REG_FEEDBACK   = 2'd2;
	localparam logic [1:0] REG_LOOP_NORM  = 2'd3;

	// micro-op sequence of one sample
	localparam logic [3:0] OP_H0   = 4'd0;
	localparam logic [3:0] OP_H1   = 4'd1;
	localparam logic [3:0] OP_H2   = 4'd2;
	localparam logic [3:0] OP_S    = 4'd3;
	localparam logic [3:0] OP_F    = 4'd4;
	localparam logic [3:0] OP_N    = 4'd5;
	localparam logic [3:0] OP_T    = 4'd6;
	localparam logic [3:0] OP_L0   = 4'd7;
	localparam logic [3:0] OP_L1   = 4'd8;
	localparam logic [3:0] OP_L2   = 4'd9;
	localparam logic [3:0] OP_LAST = 4'd10;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_PREP = 4'b0100,
		ST_WB   = 4'b1000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
		logic signed [31:0] r;
		if (v > 43'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -43'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// tanh(i/8) in Q0.16
	function automatic logic [15:0] tanh_lut(input logic [5:0] i);
		logic [15:0] r;
		case (i)
			6'd0:  r = 16'd0;
			6'd1:  r = 16'd8150;
			6'd2:  r = 16'd16051;
			6'd3:  r = 16'd23485;
			6'd4:  r = 16'd30285;
			6'd5:  r = 16'd36346;
			6'd6:  r = 16'd41625;
			6'd7:  r = 16'd46131;
			6'd8:  r = 16'd49912;
			6'd9:  r = 16'd53038;
			6'd10: r = 16'd55593;
			6'd11: r = 16'd57660;
			6'd12: r = 16'd59320;
			6'd13: r = 16'd60643;
			6'd14: r = 16'd61694;
			6'd15: r = 16'd62524;
			6'd16: r = 16'd63179;
			6'd17: r = 16'd63693;
			6'd18: r = 16'd64096;
			6'd19: r = 16'd64412;
			6'd20: r = 16'd64659;
			6'd21: r = 16'd64852;
			6'd22: r = 16'd65003;
			6'd23: r = 16'd65120;
			6'd24: r = 16'd65212;
			6'd25: r = 16'd65283;
			6'd26: r = 16'd65339;
			6'd27: r = 16'd65383;
			6'd28: r = 16'd65417;
			6'd29: r = 16'd65443;
			6'd30: r = 16'd65464;
			6'd31: r = 16'd65480;
			default: r = 16'd65492;
		endcase
		return r;
	endfunction

endpackage

// ----- src/lzf_serial_mul.sv -----
// Shift-add multiplier: one multiplier bit per cycle, LSB first.
module lzf_serial_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [lzf_pkg::AW-1:0]  a,
	input  logic        [lzf_pkg::BW-1:0]  b,
	output logic                           done,
	output logic signed [lzf_pkg::PW-1:0]  product
);

	logic signed [lzf_pkg::AW:0]   acc_q;
	logic signed [lzf_pkg::AW-1:0] a_q;
	logic        [lzf_pkg::BW-1:0] b_q;
	logic        [lzf_pkg::CW-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic signed [lzf_pkg::AW:0]   addend;
	logic signed [lzf_pkg::AW:0]   sum;

	assign addend  = b_q[0] ? {a_q[lzf_pkg::AW-1], a_q} : '0;
	assign sum     = acc_q + addend;
	assign product = {acc_q, b_q};
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lzf_pkg::CW'(lzf_pkg::BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			// add, then shift the whole product one place right
			acc_q <= sum >>> 1;
			b_q   <= {sum[0], b_q[lzf_pkg::BW-1:1]};
		end
	end

endmodule

// ----- src/ladder_lowpass_zdf_filter.sv -----
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------
// input    | in_valid / in_stall    | sample_in  (24b signed Q1.23)
// output   | out_valid / out_stall  | sample_out (24b signed Q1.23)
// config   | cfg_valid / cfg_ready  | cfg_index (2b), cfg_data (25b)
//
// One sample takes 11 multiplies on a bit-serial multiplier, with a setup state
// before each stage multiply and a write-back state after the last; the next
// input beat is taken only once the filter is back in idle. The shift-add
// multiplier works one multiplier bit per cycle.
// Reset clears the stage memories and loads the register defaults.
// A finished sample waits in the output register; the next input beat is
// taken meanwhile, and write-back holds only if that register is still full.
`include "ladder_lowpass_zdf_filter_assert.svh"

module ladder_lowpass_zdf_filter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] sample_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] sample_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [24:0] cfg_data
);

	lzf_pkg::state_t state_q;
	logic [3:0]  op_q;

	// configuration
	logic [24:0] stage_gain_q;
	logic [24:0] state_gain_q;
	logic [22:0] feedback_gain_q;
	logic [24:0] loop_norm_q;

	// stage memories, Q4.28
	logic signed [31:0] mem_q [4];

	logic signed [23:0] x_q;
	logic signed [31:0] w_q;    // running ladder value between stages
	logic               neg_q;  // sign of the tanh argument
	logic        [15:0] lo_q;   // lower table entry
	logic signed [23:0] out_q;
	logic               out_valid_q;

	logic                          mul_start;
	logic signed [lzf_pkg::AW-1:0] mul_a;
	logic        [lzf_pkg::BW-1:0] mul_b;
	logic                          mul_done;
	logic signed [lzf_pkg::PW-1:0] mul_prod;

	logic               in_take;
	logic [1:0]         hidx;
	logic [1:0]         sidx;
	logic [1:0]         zsel;
	logic signed [31:0] z;
	logic signed [37:0] p24;
	logic signed [41:0] p20;
	logic signed [36:0] p25;
	logic signed [31:0] p24_sat;
	logic signed [31:0] res_sat;
	logic signed [31:0] mnew;
	logic signed [42:0] u_full;
	logic        [32:0] mag;
	logic               big;
	logic        [5:0]  tidx;
	logic        [15:0] lo_v;
	logic        [15:0] hi_v;
	logic        [16:0] t_sum;
	logic signed [31:0] r_pos;
	logic signed [31:0] y_t;
	logic signed [32:0] diff_yz;
	logic signed [26:0] y_out;
	logic signed [23:0] y_clamp;
	logic               wb_go;

	assign in_stall  = (state_q != lzf_pkg::ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign sample_out = out_q;
	assign wb_go     = (state_q == lzf_pkg::ST_WB) && (!out_valid_q || !out_stall);

	lzf_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	// one memory read: Horner ops use the next memory, stage ops their own
	assign hidx = op_q[1:0] + 2'd1;
	assign sidx = 2'(op_q - lzf_pkg::OP_L0);
	assign zsel = (op_q < lzf_pkg::OP_L0) ? hidx : sidx;
	assign z    = mem_q[zsel];

	// product taps, floor shifts come for free from the arithmetic shift
	assign p24 = mul_prod[lzf_pkg::PW-1:24];
	assign p20 = mul_prod[lzf_pkg::PW-1:20];
	assign p25 = mul_prod[lzf_pkg::PW-1:25];

	assign p24_sat = lzf_pkg::sat32({{5{p24[37]}}, p24});
	assign res_sat = lzf_pkg::sat32({{5{p24[37]}}, p24} + {{11{z[31]}}, z});
	assign mnew    = lzf_pkg::sat32({{11{res_sat[31]}}, res_sat} + {{5{p24[37]}}, p24});

	// loop input before normalization: x*32 - s*k
	assign u_full = {{14{x_q[23]}}, x_q, 5'b0} - {p20[41], p20};

	// tanh table setup from the normalized loop input
	assign mag  = p24_sat[31] ? 33'(-{p24_sat[31], p24_sat}) : {1'b0, p24_sat};
	assign big  = |mag[32:30];
	assign tidx = {1'b0, mag[29:25]};
	assign lo_v = big ? lzf_pkg::tanh_lut(6'd32) : lzf_pkg::tanh_lut(tidx);
	assign hi_v = big ? lzf_pkg::tanh_lut(6'd32) : lzf_pkg::tanh_lut(tidx + 6'd1);

	// interpolation result, scaled to Q4.28 and signed
	assign t_sum = {1'b0, lo_q} + {1'b0, p25[15:0]};
	assign r_pos = {4'b0, t_sum[15:0], 12'b0};
	assign y_t   = neg_q ? -r_pos : r_pos;

	assign diff_yz = {w_q[31], w_q} - {z[31], z};

	// output: Q4.28 to Q1.23 with saturation
	assign y_out   = w_q[31:5];
	assign y_clamp = (y_out[26:23] == {4{y_out[23]}}) ? y_out[23:0]
		: (y_out[26] ? 24'sh800000 : 24'sh7fffff);

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = stage_gain_q;
		if (in_take) begin
			mul_start = 1'b1;
			mul_a     = lzf_pkg::AW'(mem_q[0]);
		end else if (state_q == lzf_pkg::ST_PREP) begin
			mul_start = 1'b1;
			mul_a     = lzf_pkg::AW'(diff_yz);
		end else if (state_q == lzf_pkg::ST_MUL && mul_done) begin
			case (op_q)
				lzf_pkg::OP_H0, lzf_pkg::OP_H1: begin
					mul_start = 1'b1;
					mul_a     = lzf_pkg::AW'(res_sat);
				end
				lzf_pkg::OP_H2: begin
					mul_start = 1'b1;
					mul_a     = lzf_pkg::AW'(res_sat);
					mul_b     = state_gain_q;
				end
				lzf_pkg::OP_S: begin
					mul_start = 1'b1;
					mul_a     = lzf_pkg::AW'(p24_sat);
					mul_b     = {2'b0, feedback_gain_q};
				end
				lzf_pkg::OP_F: begin
					mul_start = 1'b1;
					mul_a     = u_full[lzf_pkg::AW-1:0];
					mul_b     = loop_norm_q;
				end
				lzf_pkg::OP_N: begin
					mul_start = 1'b1;
					mul_a     = lzf_pkg::AW'({1'b0, hi_v - lo_v});
					mul_b     = mag[24:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= lzf_pkg::ST_IDLE;
			op_q            <= lzf_pkg::OP_H0;
			out_valid_q     <= 1'b0;
			stage_gain_q    <= 25'd0;
			state_gain_q    <= 25'd16777216;
			feedback_gain_q <= 23'd0;
			loop_norm_q     <= 25'd16777216;
			for (int i = 0; i < 4; i++) begin
				mem_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					lzf_pkg::REG_STAGE_GAIN: stage_gain_q    <= cfg_data;
					lzf_pkg::REG_STATE_GAIN: state_gain_q    <= cfg_data;
					lzf_pkg::REG_FEEDBACK:   feedback_gain_q <= cfg_data[22:0];
					lzf_pkg::REG_LOOP_NORM:  loop_norm_q     <= cfg_data;
					default: begin
					end
				endcase
			end

			// raise the output beat on write-back, drop it once taken
			if (wb_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				lzf_pkg::ST_IDLE: begin
					if (in_take) begin
						op_q    <= lzf_pkg::OP_H0;
						state_q <= lzf_pkg::ST_MUL;
					end
				end
				lzf_pkg::ST_PREP: begin
					state_q <= lzf_pkg::ST_MUL;
				end
				lzf_pkg::ST_MUL: begin
					if (mul_done) begin
						case (op_q)
							lzf_pkg::OP_T: begin
								op_q    <= lzf_pkg::OP_L0;
								state_q <= lzf_pkg::ST_PREP;
							end
							lzf_pkg::OP_L0, lzf_pkg::OP_L1, lzf_pkg::OP_L2: begin
								mem_q[sidx] <= mnew;
								op_q        <= op_q + 4'd1;
								state_q     <= lzf_pkg::ST_PREP;
							end
							lzf_pkg::OP_LAST: begin
								mem_q[sidx] <= mnew;
								state_q     <= lzf_pkg::ST_WB;
							end
							default: begin
								op_q <= op_q + 4'd1;
							end
						endcase
					end
				end
				lzf_pkg::ST_WB: begin
					// hold until the output register is free
					if (wb_go)
						state_q <= lzf_pkg::ST_IDLE;
				end
				default: begin
					state_q <= lzf_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take)
			x_q <= sample_in;
		if (state_q == lzf_pkg::ST_MUL && mul_done) begin
			if (op_q == lzf_pkg::OP_N) begin
				neg_q <= p24_sat[31];
				lo_q  <= lo_v;
			end
			if (op_q == lzf_pkg::OP_T)
				w_q <= y_t;
			else if (op_q >= lzf_pkg::OP_L0)
				w_q <= res_sat;
		end
		if (wb_go)
			out_q <= y_clamp;
	end

	`LZF_ASSERT(a_take_starts_mul, in_take |=> state_q == lzf_pkg::ST_MUL, "accepted beat did not start")
	`LZF_ASSERT(a_done_in_mul, mul_done |-> state_q == lzf_pkg::ST_MUL, "multiplier done outside a multiply")
	`LZF_ASSERT(a_op_range, state_q == lzf_pkg::ST_MUL |-> op_q <= lzf_pkg::OP_LAST, "micro-op beyond sequence")
	`LZF_ASSERT_RST(a_rst_out, !arst_n |-> !out_valid_q, "output valid during reset")

endmodule
